FILE: rtl/sfpd_pkg.sv
// Shared types, constants and the likelihood-to-probability table for the dosage block.
`timescale 1ns / 1ps

package sfpd_pkg;

	localparam int MAX_SUBFIELDS  = 16;
	localparam int PROB_FRAC_BITS = 24;
	localparam int DOSE_FRAC_BITS = 14;
	localparam int GENOTYPE_COUNT = 3;

	localparam int SUB_W   = $clog2(MAX_SUBFIELDS);
	localparam int PROB_W  = PROB_FRAC_BITS + 1;  // a likelihood of zero maps to exactly 1.0
	localparam int SUM_W   = PROB_W + 1;          // sum of three probabilities, or p1 + 2*p2
	localparam int DIV_W   = SUM_W + 1;           // twice the sum
	localparam int QUOT_W  = DOSE_FRAC_BITS + 2;  // Q2.DOSE_FRAC_BITS
	localparam int STEP_W  = $clog2(QUOT_W);

	localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(MAX_SUBFIELDS - 1);
	localparam logic [1:0] VAL_FULL = 2'(GENOTYPE_COUNT);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_W - 1);

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_SHORT    = 2'd1;
	localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;
	localparam logic [1:0] STATUS_ZERO_SUM = 2'd3;

	typedef enum logic [4:0] {
		ST_PARSE = 5'b00001,
		ST_LOOK  = 5'b00010,
		ST_SUM   = 5'b00100,
		ST_DIV   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	typedef logic [GENOTYPE_COUNT-1:0][7:0] store_t;

	typedef struct packed {
		logic [SUB_W-1:0] sub;
		logic [1:0]       val;
		logic [7:0]       acc;
		logic             seen;
		logic [1:0]       err;
		store_t           store;
	} parse_t;

	typedef logic [255:0][PROB_W-1:0] prob_table_t;

	// 10^(-r/10) scaled by 2^62 for r = 0..9.
	localparam logic [9:0][63:0] TENTH_POWERS = {
		64'd580576872000000000,  64'd730902976000000000,
		64'd920152332000000000,  64'd1158403153000000000,
		64'd1458343164000000000, 64'd1835945271000000000,
		64'd2311318157000000000, 64'd2909777164000000000,
		64'd3663192414130000000, 64'd4611686018427387904
	};

	// Evaluated at elaboration only: each decade divides the mantissa by ten with rounding.
	function automatic prob_table_t build_prob_table();
		prob_table_t t;
		logic [63:0] v;
		for (int pl = 0; pl < 256; pl++) begin
			v = TENTH_POWERS[pl % 10];
			for (int i = 0; i < 26; i++) begin
				if (i < pl / 10) begin
					v = (v + 64'd5) / 64'd10;
				end
			end
			v = (v + (64'd1 << (61 - PROB_FRAC_BITS))) >> (62 - PROB_FRAC_BITS);
			t[pl] = v[PROB_W-1:0];
		end
		return t;
	endfunction

	localparam prob_table_t PROB_TABLE = build_prob_table();

endpackage

FILE: rtl/sample_field_pl_dosage.sv
// Top level: sample field parser, probability lookup and iterative dosage divider.
`timescale 1ns / 1ps

// The block reads one byte of a genotype sample field per cycle and keeps pace with the input
// stream until the byte marked by tlast. After that byte it looks up the three likelihoods,
// sums them and runs a restoring divider that yields one quotient bit per cycle, so it holds
// s_tready low through the lookup, the sum, sixteen divide steps and the hand-off before
// the next field may start. A field that ends in an error goes straight to the hand-off;
// a zero sum skips the divide. The result waits in an output register, so parsing of the
// next field goes on while it is not yet taken; the hand-off cycle repeats until that
// register is free.
module sample_field_pl_dosage (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] field_byte, [11:8] pl_position, [15:12] zero
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] dosage
	output logic [1:0]  m_tuser    // [1:0] status
);

	sfpd_pkg::state_t state_q;
	sfpd_pkg::parse_t par_q;
	sfpd_pkg::parse_t par_next;
	sfpd_pkg::parse_t par_fin;

	sfpd_pkg::store_t job_store_q;
	logic [1:0] job_err_q;

	logic [sfpd_pkg::GENOTYPE_COUNT-1:0][sfpd_pkg::PROB_W-1:0] prob_q;
	logic [sfpd_pkg::SUM_W-1:0] num_sum;
	logic [sfpd_pkg::SUM_W-1:0] den_sum;

	logic [sfpd_pkg::DIV_W-1:0]  rem_q;
	logic [sfpd_pkg::DIV_W-1:0]  dvs_q;
	logic [sfpd_pkg::DIV_W:0]    trial;
	logic                        trial_ge;
	logic [sfpd_pkg::STEP_W-1:0] step_q;
	logic [sfpd_pkg::QUOT_W-1:0] quot_q;
	logic [1:0]                  stat_q;

	logic        out_valid_q;
	logic [15:0] out_dose_q;
	logic [1:0]  out_stat_q;

	logic [7:0] field_byte;
	logic [sfpd_pkg::SUB_W-1:0] pl_position;
	logic       in_accept;
	logic       in_pl;
	logic       is_digit;
	logic [11:0] acc_mul;

	assign field_byte  = s_tdata[7:0];
	assign pl_position = s_tdata[8 +: sfpd_pkg::SUB_W];
	assign s_tready    = (state_q == sfpd_pkg::ST_PARSE);
	assign in_accept   = s_tvalid && s_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_dose_q;
	assign m_tuser  = out_stat_q;

	// Finishes the value being read; a value with no digit is an error.
	function automatic sfpd_pkg::parse_t close_value(sfpd_pkg::parse_t p);
		sfpd_pkg::parse_t n;
		n = p;
		if (!p.seen) begin
			n.err = sfpd_pkg::STATUS_SHORT;
		end else if (p.val < sfpd_pkg::VAL_FULL) begin
			n.store[p.val] = p.acc;
			n.val = p.val + 2'd1;
		end
		n.acc  = 8'd0;
		n.seen = 1'b0;
		return n;
	endfunction

	always_comb begin
		par_next = par_q;
		in_pl = (par_q.err == sfpd_pkg::STATUS_OK) && (par_q.sub == pl_position) &&
			(par_q.val < sfpd_pkg::VAL_FULL);
		is_digit = (field_byte >= sfpd_pkg::CHAR_ZERO) && (field_byte <= sfpd_pkg::CHAR_NINE);
		acc_mul = ({4'd0, par_q.acc} * 12'd10) + {4'd0, field_byte - sfpd_pkg::CHAR_ZERO};

		if (field_byte == sfpd_pkg::CHAR_COLON) begin
			if (in_pl) begin
				par_next = close_value(par_next);
				if (par_next.err == sfpd_pkg::STATUS_OK && par_next.val < sfpd_pkg::VAL_FULL) begin
					par_next.err = sfpd_pkg::STATUS_SHORT;
				end
			end
			if (par_q.sub < sfpd_pkg::SUB_LAST) begin
				par_next.sub = par_q.sub + 1'b1;
			end
		end else if (in_pl) begin
			if (is_digit) begin
				par_next.acc  = (acc_mul > 12'd255) ? 8'd255 : acc_mul[7:0];
				par_next.seen = 1'b1;
			end else if (field_byte == sfpd_pkg::CHAR_COMMA) begin
				par_next = close_value(par_next);
			end else begin
				par_next.err = sfpd_pkg::STATUS_BAD_CHAR;
			end
		end

		// The end of the field closes the value still open in the likelihood subfield.
		par_fin = par_next;
		if (par_fin.err == sfpd_pkg::STATUS_OK && par_fin.val < sfpd_pkg::VAL_FULL) begin
			if (par_fin.sub == pl_position) begin
				par_fin = close_value(par_fin);
			end
			if (par_fin.err == sfpd_pkg::STATUS_OK && par_fin.val < sfpd_pkg::VAL_FULL) begin
				par_fin.err = sfpd_pkg::STATUS_SHORT;
			end
		end
	end

	assign num_sum = sfpd_pkg::SUM_W'(prob_q[1]) + {prob_q[2], 1'b0};
	assign den_sum = sfpd_pkg::SUM_W'(prob_q[0]) + sfpd_pkg::SUM_W'(prob_q[1]) +
		sfpd_pkg::SUM_W'(prob_q[2]);

	// The divisor is held doubled, so the first step compares the bare numerator against it
	// and every later step doubles the partial remainder first.
	assign trial    = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign trial_ge = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sfpd_pkg::ST_PARSE;
			par_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == sfpd_pkg::ST_DONE && (!out_valid_q || m_tready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				sfpd_pkg::ST_PARSE: begin
					if (in_accept) begin
						if (s_tlast) begin
							par_q <= '0;
							state_q <= (par_fin.err == sfpd_pkg::STATUS_OK) ?
								sfpd_pkg::ST_LOOK : sfpd_pkg::ST_DONE;
						end else begin
							par_q <= par_next;
						end
					end
				end
				sfpd_pkg::ST_LOOK: begin
					state_q <= sfpd_pkg::ST_SUM;
				end
				sfpd_pkg::ST_SUM: begin
					step_q  <= '0;
					state_q <= (den_sum == '0) ? sfpd_pkg::ST_DONE : sfpd_pkg::ST_DIV;
				end
				sfpd_pkg::ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == sfpd_pkg::STEP_LAST) begin
						state_q <= sfpd_pkg::ST_DONE;
					end
				end
				sfpd_pkg::ST_DONE: begin
					if (!out_valid_q || m_tready) begin
						state_q <= sfpd_pkg::ST_PARSE;
					end
				end
				default: begin
					state_q <= sfpd_pkg::ST_PARSE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			sfpd_pkg::ST_PARSE: begin
				if (in_accept && s_tlast) begin
					job_store_q <= par_fin.store;
					job_err_q   <= par_fin.err;
					stat_q      <= par_fin.err;
					quot_q      <= '0;
				end
			end
			sfpd_pkg::ST_LOOK: begin
				for (int g = 0; g < sfpd_pkg::GENOTYPE_COUNT; g++) begin
					prob_q[g] <= sfpd_pkg::PROB_TABLE[job_store_q[g]];
				end
			end
			sfpd_pkg::ST_SUM: begin
				rem_q <= sfpd_pkg::DIV_W'(num_sum);
				dvs_q <= {den_sum, 1'b0};
				if (den_sum == '0) begin
					stat_q <= sfpd_pkg::STATUS_ZERO_SUM;
				end else begin
					stat_q <= job_err_q;
				end
			end
			sfpd_pkg::ST_DIV: begin
				if (trial_ge) begin
					rem_q <= sfpd_pkg::DIV_W'(trial - {1'b0, dvs_q});
				end else begin
					rem_q <= trial[sfpd_pkg::DIV_W-1:0];
				end
				quot_q <= {quot_q[sfpd_pkg::QUOT_W-2:0], trial_ge};
			end
			sfpd_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					out_dose_q <= (stat_q == sfpd_pkg::STATUS_OK) ? 16'(quot_q) : 16'd0;
					out_stat_q <= stat_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: tb/sample_field_pl_dosage_tb.sv
// Testbench for the sample field likelihood-to-dosage block: stream stimulus and scoreboard.
`timescale 1ns / 1ps

module sample_field_pl_dosage_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;

	// 10^(-r/10) scaled by 2^62, one entry per last decimal digit of the likelihood.
	localparam longint unsigned DECIBEL_MANT [10] = '{
		64'd4611686018427387904, 64'd3663192414130000000, 64'd2909777164000000000,
		64'd2311318157000000000, 64'd1835945271000000000, 64'd1458343164000000000,
		64'd1158403153000000000, 64'd920152332000000000,  64'd730902976000000000,
		64'd580576872000000000
	};

	typedef struct {
		logic [15:0] dosage;
		logic [1:0]  status;
	} dose_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // [7:0] field_byte, [11:8] pl_position, [15:12] zero
	logic        s_tlast;   // last_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [15:0] dosage
	logic [1:0]  m_tuser;   // [1:0] status

	// Parser state of the predictor.
	logic [sfpd_pkg::SUB_W-1:0] cur_sub;
	logic [1:0]       vals_read;
	logic [7:0]       digit_acc;
	bit               digit_seen;
	logic [7:0]       pl_vals [sfpd_pkg::GENOTYPE_COUNT];
	logic [1:0]       parse_err;

	dose_result_t expected_doses[$];
	logic [7:0]   field_bytes[$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_reqs;
	int hold_done;
	int hold_left;
	int mismatches;
	int cycle_count;

	sample_field_pl_dosage u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (hold_left == 0 && hold_reqs != hold_done) begin
			hold_done++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready = 1'b0;
		end else begin
			m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	function automatic longint unsigned phred_prob(logic [7:0] pl);
		longint unsigned m;
		m = DECIBEL_MANT[pl % 10];
		for (int i = 0; i < pl / 10; i++) begin
			m = (m + 64'd5) / 64'd10;
		end
		return (m + (64'd1 << (61 - sfpd_pkg::PROB_FRAC_BITS))) >>
			(62 - sfpd_pkg::PROB_FRAC_BITS);
	endfunction

	function automatic void clear_parser();
		cur_sub = '0;
		vals_read = '0;
		digit_acc = '0;
		digit_seen = 1'b0;
		parse_err = sfpd_pkg::STATUS_OK;
		for (int i = 0; i < sfpd_pkg::GENOTYPE_COUNT; i++) begin
			pl_vals[i] = '0;
		end
	endfunction

	// A value closed without any digit counts as a short subfield.
	function automatic void close_likelihood();
		if (!digit_seen) begin
			parse_err = sfpd_pkg::STATUS_SHORT;
		end else if (vals_read < sfpd_pkg::GENOTYPE_COUNT) begin
			pl_vals[vals_read] = digit_acc;
			vals_read++;
		end
		digit_acc = '0;
		digit_seen = 1'b0;
	endfunction

	function automatic void predict_dosage(logic [7:0] b, logic [3:0] pos, logic last);
		bit              in_pl;
		int              nv;
		longint unsigned p0, p1, p2, num, den, quo;
		dose_result_t    r;
		in_pl = (parse_err == sfpd_pkg::STATUS_OK) && (cur_sub == pos) &&
			(vals_read < sfpd_pkg::GENOTYPE_COUNT);
		if (b == sfpd_pkg::CHAR_COLON) begin
			if (in_pl) begin
				close_likelihood();
				if (parse_err == sfpd_pkg::STATUS_OK && vals_read < sfpd_pkg::GENOTYPE_COUNT) begin
					parse_err = sfpd_pkg::STATUS_SHORT;
				end
			end
			if (cur_sub < sfpd_pkg::MAX_SUBFIELDS - 1) begin
				cur_sub++;
			end
		end else if (in_pl) begin
			if (b >= sfpd_pkg::CHAR_ZERO && b <= sfpd_pkg::CHAR_NINE) begin
				nv = int'(digit_acc) * 10 + int'(b) - int'(sfpd_pkg::CHAR_ZERO);
				digit_acc = (nv > 255) ? 8'd255 : 8'(nv);
				digit_seen = 1'b1;
			end else if (b == sfpd_pkg::CHAR_COMMA) begin
				close_likelihood();
			end else begin
				parse_err = sfpd_pkg::STATUS_BAD_CHAR;
			end
		end
		if (!last) begin
			return;
		end
		// The field end closes a value that is still open in the likelihood subfield.
		if (parse_err == sfpd_pkg::STATUS_OK && vals_read < sfpd_pkg::GENOTYPE_COUNT) begin
			if (cur_sub == pos) begin
				close_likelihood();
			end
			if (parse_err == sfpd_pkg::STATUS_OK && vals_read < sfpd_pkg::GENOTYPE_COUNT) begin
				parse_err = sfpd_pkg::STATUS_SHORT;
			end
		end
		r.status = parse_err;
		r.dosage = '0;
		if (parse_err == sfpd_pkg::STATUS_OK) begin
			p0 = phred_prob(pl_vals[0]);
			p1 = phred_prob(pl_vals[1]);
			p2 = phred_prob(pl_vals[2]);
			num = p1 + 2 * p2;
			den = p0 + p1 + p2;
			if (den == 0) begin
				r.status = sfpd_pkg::STATUS_ZERO_SUM;
			end else begin
				quo = (num << sfpd_pkg::DOSE_FRAC_BITS) / den;
				r.dosage = (quo > 64'd65535) ? 16'hFFFF : quo[15:0];
			end
		end
		expected_doses.insert(expected_doses.size(), r);
		clear_parser();
	endfunction

	task automatic note_mismatch(string what, int exp_v, int act_v);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin
		dose_result_t r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_doses.size() == 0) begin
				note_mismatch("unexpected result, dosage", -1, m_tdata);
			end else begin
				r = expected_doses.pop_front();
				if (m_tdata !== r.dosage) begin
					note_mismatch("dosage", r.dosage, m_tdata);
				end
				if (m_tuser !== r.status) begin
					note_mismatch("status", r.status, m_tuser);
				end
			end
		end
	end

	// Called just after a falling edge; returns just after the falling edge that follows the
	// transaction. Valid stays high, so a following item goes out without a gap unless idle time is drawn.
	task automatic send_item(logic [7:0] b, logic [3:0] pos, logic last);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {4'h0, pos, b};
		s_tlast = last;
		do @(posedge clk); while (!s_tready);
		predict_dosage(b, pos, last);
		@(negedge clk);
	endtask

	task automatic send_text(string txt, logic [3:0] pos);
		for (int i = 0; i < txt.len(); i++) begin
			send_item(txt[i], pos, i == txt.len() - 1);
		end
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (expected_doses.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	function automatic void add_field_byte(logic [7:0] b);
		field_bytes.insert(field_bytes.size(), b);
	endfunction

	function automatic void append_number(int n);
		string txt;
		if ($urandom_range(0, 9) == 0) begin
			add_field_byte(sfpd_pkg::CHAR_ZERO);
		end
		txt = $sformatf("%0d", n);
		for (int i = 0; i < txt.len(); i++) begin
			add_field_byte(txt[i]);
		end
	endfunction

	// Fills field_bytes with one sample field. Most fields are well formed with the
	// likelihoods at pos; some are damaged, and a few are pure noise.
	function automatic void build_field(output logic [3:0] pos, output bit noise);
		int  nsub, nvals, kind, at;
		bit  high_pl;
		logic [7:0] c;
		field_bytes.delete();
		noise = ($urandom_range(0, 19) == 0);
		pos = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(4, 15));
		if (noise) begin
			repeat ($urandom_range(1, 6)) add_field_byte(8'($urandom_range(0, 255)));
			return;
		end
		nsub = pos + 1 + $urandom_range(0, 2);
		nvals = ($urandom_range(0, 4) != 0) ? sfpd_pkg::GENOTYPE_COUNT : $urandom_range(1, 5);
		high_pl = ($urandom_range(0, 9) == 0);
		for (int s = 0; s < nsub; s++) begin
			if (s > 0) begin
				add_field_byte(sfpd_pkg::CHAR_COLON);
			end
			if (s == pos) begin
				for (int k = 0; k < nvals; k++) begin
					if (k > 0) begin
						add_field_byte(sfpd_pkg::CHAR_COMMA);
					end
					kind = $urandom_range(0, 19);
					if (high_pl) append_number($urandom_range(75, 300));
					else if (kind < 12) append_number($urandom_range(0, 30));
					else if (kind < 17) append_number($urandom_range(31, 120));
					else append_number($urandom_range(121, 9999));
				end
			end else begin
				repeat ($urandom_range(0, 4)) begin
					c = 8'($urandom_range(33, 126));
					add_field_byte(c == sfpd_pkg::CHAR_COLON ? sfpd_pkg::CHAR_COMMA : c);
				end
			end
		end
		if (field_bytes.size() == 0) begin
			add_field_byte(sfpd_pkg::CHAR_ZERO);
		end
		if ($urandom_range(0, 4) == 0) begin
			at = $urandom_range(0, field_bytes.size() - 1);
			case ($urandom_range(0, 3))
				0: field_bytes[at] = 8'($urandom_range(0, 255));
				1: field_bytes.insert(at, sfpd_pkg::CHAR_COMMA);
				2: if (field_bytes.size() > 1) field_bytes.delete(at);
				default: while (field_bytes.size() > at + 1) void'(field_bytes.pop_back());
			endcase
		end
	endfunction

	task automatic send_field(logic [3:0] pos, bit wander_pos);
		logic [3:0] p;
		for (int i = 0; i < field_bytes.size(); i++) begin
			p = wander_pos ? 4'($urandom_range(0, 15)) : pos;
			send_item(field_bytes[i], p, i == field_bytes.size() - 1);
		end
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_text("0,0,0", 4'd0);        // equal likelihoods, dosage of exactly one
		send_text("99,99,999", 4'd0);    // every probability rounds to zero, value saturates
		send_text(":0,,1", 4'd1);        // empty value
		send_text("2,Q", 4'd0);          // bad character inside the likelihoods
		send_text("3,1", 4'd0);          // field ends after two values
		send_text("5:1", 4'd0);          // subfield closes after one value
		send_text("1,2,3,4:", 4'd0);     // extra values are skipped
		send_text("40,0,80", 4'd0);
		send_item(8'hFF, 4'd15, 1'b1);   // likelihood subfield never reached
		send_item(8'h00, 4'd0, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
		int         sent;
		logic [3:0] pos;
		bit         noise;
		bit         wander;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			build_field(pos, noise);
			wander = ($urandom_range(0, 19) == 0);
			send_field(pos, wander);
			if (!noise && !wander) begin
				sent += field_bytes.size();
			end
			if ($urandom_range(0, 39) == 0) begin
				wait_drained();
			end
		end
		wait_drained();
	endtask

	// The output is held off for a long stretch while fields keep arriving back to back,
	// so the result register fills and the block has to stall its input.
	task automatic test_output_hold();
		logic [3:0] pos;
		bit         noise;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_reqs++;
		repeat (12) begin
			build_field(pos, noise);
			send_field(pos, 1'b0);
		end
		wait_drained();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_reqs = 0;
		hold_done = 0;
		hold_left = 0;
		mismatches = 0;
		cycle_count = 0;
		clear_parser();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random_traffic(220, 0, 0);
		test_random_traffic(220, 55, 0);
		test_output_hold();
		test_random_traffic(220, 0, 55);
		test_random_traffic(220, 33, 33);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_doses.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: sample_field_pl_dosage.f
rtl/sfpd_pkg.sv
rtl/sample_field_pl_dosage.sv
tb/sample_field_pl_dosage_tb.sv
